// ----- rtl/nts_pkg.sv -----
// Shared types and constants for the note token stream parser.
// No dependencies; every other file refers to this package by scoped names.

package nts_pkg;

   localparam int FIELD_W     = 8;
   localparam int TPWN_W      = 12;
   localparam int PROD_W      = FIELD_W + TPWN_W;
   localparam int DIV_STEPS   = PROD_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int TIME_W      = 32;
   localparam int ONSET_W     = 20;
   localparam int ONSET_BITS  = 20;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [TPWN_W-1:0] TPWN_RESET = 12'd96;

   localparam logic [1:0] EV_NOTE  = 2'd0;
   localparam logic [1:0] EV_TRACK = 2'd1;
   localparam logic [1:0] EV_PIECE = 2'd2;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_N     = 8'h4E;

   typedef enum logic [3:0] {
      PM_IDLE,
      PM_SKIPR,
      PM_NUMER,
      PM_DENOM,
      PM_POS,
      PM_NMARK,
      PM_NSKIP,
      PM_PITCH,
      PM_DUR,
      PM_VEL,
      PM_TRACK
   } parse_mode_type;

   typedef enum logic [2:0] {
      OP_TRACK,
      OP_PIECE,
      OP_MEASURE,
      OP_POS,
      OP_NOTE
   } op_kind_type;

   typedef enum logic {
      BK_RUN,
      BK_DIV
   } back_state_type;

   // a: pitch / numerator / position, b: duration / denominator
   typedef struct packed {
      op_kind_type        kind;
      logic               cont;
      logic [FIELD_W-1:0] a;
      logic [FIELD_W-1:0] b;
      logic [FIELD_W-1:0] vel;
      logic [FIELD_W-1:0] track;
   } op_type;

endpackage

// ----- rtl/nts_front.sv -----
// Byte front end: token state machine and base-36 field accumulation.
// Depends on nts_pkg; emits one operation per completed token into the queue.

module nts_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         byte_valid,
   input  logic [7:0]                   byte_data,
   input  logic                         queue_full,
   output logic                         byte_ready,
   output logic                         push,
   output nts_pkg::op_type              push_op
);

   nts_pkg::parse_mode_type mode_ff, mode_in;
   logic [nts_pkg::FIELD_W-1:0] accum_ff, accum_in;
   logic neg_ff, neg_in;
   logic at_start_ff, at_start_in;
   logic [nts_pkg::FIELD_W-1:0] num_ff, num_in;
   logic pcont_ff, pcont_in;
   logic [nts_pkg::FIELD_W-1:0] ppitch_ff, ppitch_in;
   logic [nts_pkg::FIELD_W-1:0] pdur_ff, pdur_in;
   logic [nts_pkg::FIELD_W-1:0] pvel_ff, pvel_in;

   logic                        take_byte;
   logic                        do_feed;
   logic                        do_take;
   logic                        is_digit;
   logic [5:0]                  dval;
   logic [nts_pkg::FIELD_W-1:0] fed_accum;
   logic [nts_pkg::FIELD_W-1:0] taken;

   // no transfer is taken while reset is held
   assign byte_ready = !reset && !queue_full;
   assign take_byte  = byte_valid && byte_ready;

   always_comb begin
      is_digit = 1'b0;
      dval     = '0;
      if (byte_data inside {[8'h30:8'h39]}) begin
         is_digit = 1'b1;
         dval     = 6'(byte_data - 8'h30);
      end else if (byte_data inside {[8'h41:8'h5A]}) begin
         is_digit = 1'b1;
         dval     = 6'(byte_data - 8'h37);
      end
   end

   assign fed_accum = nts_pkg::FIELD_W'(16'(accum_ff) * 16'd36 + 16'(dval));
   assign taken     = neg_ff ? nts_pkg::FIELD_W'(9'd0 - 9'(accum_ff)) : accum_ff;

   always_comb begin
      mode_in     = mode_ff;
      accum_in    = accum_ff;
      neg_in      = neg_ff;
      at_start_in = at_start_ff;
      num_in      = num_ff;
      pcont_in    = pcont_ff;
      ppitch_in   = ppitch_ff;
      pdur_in     = pdur_ff;
      pvel_in     = pvel_ff;
      do_feed     = 1'b0;
      do_take     = 1'b0;
      push        = 1'b0;
      push_op     = '0;
      push_op.kind = nts_pkg::OP_TRACK;

      if (take_byte) begin
         case (mode_ff)
            nts_pkg::PM_IDLE: begin
               if (byte_data == nts_pkg::CH_R) begin
                  mode_in      = nts_pkg::PM_SKIPR;
                  push         = 1'b1;
                  push_op.kind = nts_pkg::OP_TRACK;
               end else if (byte_data == nts_pkg::CH_M) begin
                  mode_in = nts_pkg::PM_NUMER;
               end else if (byte_data == nts_pkg::CH_P) begin
                  mode_in = nts_pkg::PM_POS;
               end else if (byte_data == nts_pkg::CH_N) begin
                  pcont_in = 1'b0;
                  mode_in  = nts_pkg::PM_NMARK;
               end else if (byte_data == nts_pkg::CH_NL) begin
                  push         = 1'b1;
                  push_op.kind = nts_pkg::OP_PIECE;
               end
            end
            nts_pkg::PM_SKIPR: begin
               if (byte_data == nts_pkg::CH_SPACE) mode_in = nts_pkg::PM_IDLE;
            end
            nts_pkg::PM_NUMER: begin
               if (byte_data == nts_pkg::CH_SLASH) begin
                  num_in  = taken;
                  do_take = 1'b1;
                  mode_in = nts_pkg::PM_DENOM;
               end else begin
                  do_feed = 1'b1;
               end
            end
            nts_pkg::PM_DENOM: begin
               if (byte_data == nts_pkg::CH_SPACE) begin
                  push         = 1'b1;
                  push_op.kind = nts_pkg::OP_MEASURE;
                  push_op.a    = num_ff;
                  push_op.b    = taken;
                  do_take      = 1'b1;
                  mode_in      = nts_pkg::PM_IDLE;
               end else begin
                  do_feed = 1'b1;
               end
            end
            nts_pkg::PM_POS: begin
               if (byte_data == nts_pkg::CH_SPACE) begin
                  push         = 1'b1;
                  push_op.kind = nts_pkg::OP_POS;
                  push_op.a    = taken;
                  do_take      = 1'b1;
                  mode_in      = nts_pkg::PM_IDLE;
               end else begin
                  do_feed = 1'b1;
               end
            end
            nts_pkg::PM_NMARK: begin
               if (byte_data == nts_pkg::CH_TILDE) begin
                  pcont_in = 1'b1;
                  mode_in  = nts_pkg::PM_NSKIP;
               end else begin
                  mode_in = nts_pkg::PM_PITCH;
               end
            end
            nts_pkg::PM_NSKIP: begin
               mode_in = nts_pkg::PM_PITCH;
            end
            nts_pkg::PM_PITCH: begin
               if (byte_data == nts_pkg::CH_COLON) begin
                  ppitch_in = taken;
                  do_take   = 1'b1;
                  mode_in   = nts_pkg::PM_DUR;
               end else begin
                  do_feed = 1'b1;
               end
            end
            nts_pkg::PM_DUR: begin
               if (byte_data == nts_pkg::CH_COLON) begin
                  pdur_in = taken;
                  do_take = 1'b1;
                  mode_in = nts_pkg::PM_VEL;
               end else begin
                  do_feed = 1'b1;
               end
            end
            nts_pkg::PM_VEL: begin
               if (byte_data == nts_pkg::CH_COLON) begin
                  pvel_in = taken;
                  do_take = 1'b1;
                  mode_in = nts_pkg::PM_TRACK;
               end else begin
                  do_feed = 1'b1;
               end
            end
            nts_pkg::PM_TRACK: begin
               if (byte_data == nts_pkg::CH_SPACE) begin
                  push          = 1'b1;
                  push_op.kind  = nts_pkg::OP_NOTE;
                  push_op.cont  = pcont_ff;
                  push_op.a     = ppitch_ff;
                  push_op.b     = pdur_ff;
                  push_op.vel   = pvel_ff;
                  push_op.track = taken;
                  do_take       = 1'b1;
                  mode_in       = nts_pkg::PM_IDLE;
               end else begin
                  do_feed = 1'b1;
               end
            end
            default: begin
               mode_in = nts_pkg::PM_IDLE;
            end
         endcase
      end

      // leading minus only counts as the very first field character
      if (do_feed) begin
         at_start_in = 1'b0;
         if (at_start_ff && byte_data == nts_pkg::CH_MINUS) begin
            neg_in = 1'b1;
         end else if (is_digit) begin
            accum_in = fed_accum;
         end
      end
      if (do_take) begin
         accum_in    = '0;
         neg_in      = 1'b0;
         at_start_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= nts_pkg::PM_IDLE;
         accum_ff    <= '0;
         neg_ff      <= 1'b0;
         at_start_ff <= 1'b1;
         num_ff      <= '0;
         pcont_ff    <= 1'b0;
         ppitch_ff   <= '0;
         pdur_ff     <= '0;
         pvel_ff     <= '0;
      end else begin
         mode_ff     <= mode_in;
         accum_ff    <= accum_in;
         neg_ff      <= neg_in;
         at_start_ff <= at_start_in;
         num_ff      <= num_in;
         pcont_ff    <= pcont_in;
         ppitch_ff   <= ppitch_in;
         pdur_ff     <= pdur_in;
         pvel_ff     <= pvel_in;
      end
   end

endmodule

// ----- rtl/nts_queue.sv -----
// Short operation queue between the byte front end and the back end.
// Depends on nts_pkg for the operation type and depth.

module nts_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  nts_pkg::op_type push_op,
   input  logic            pop,
   output nts_pkg::op_type pop_op,
   output logic            full,
   output logic            empty
);

   nts_pkg::op_type              mem_ff [nts_pkg::QUEUE_DEPTH];
   logic [nts_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [nts_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [nts_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign full    = (count_ff == (nts_pkg::QUEUE_AW+1)'(nts_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_op  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/nts_back.sv -----
// Back end: timing state, measure-length divider and the result register.
// Depends on nts_pkg; takes operations from nts_queue in order.

module nts_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [nts_pkg::TPWN_W-1:0]     csr_write_data,
   input  logic                           q_empty,
   input  nts_pkg::op_type                q_op,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_event_kind,
   output logic                           rsp_continued,
   output logic [nts_pkg::ONSET_W-1:0]    rsp_onset_tick,
   output logic [nts_pkg::FIELD_W-1:0]    rsp_pitch_value,
   output logic [nts_pkg::FIELD_W-1:0]    rsp_duration_value,
   output logic [nts_pkg::FIELD_W-1:0]    rsp_velocity_value,
   output logic [nts_pkg::FIELD_W-1:0]    rsp_track_number,
   output logic                           rsp_divide_error
);

   nts_pkg::back_state_type state_ff, state_in;
   logic [nts_pkg::TPWN_W-1:0]   tpwn_ff, tpwn_in;
   logic [nts_pkg::TIME_W-1:0]   start_ff, start_in;
   logic [nts_pkg::TIME_W-1:0]   len_ff, len_in;
   logic [nts_pkg::TIME_W-1:0]   time_ff, time_in;
   logic                         flag_ff, flag_in;
   logic [nts_pkg::PROD_W-1:0]   quot_ff, quot_in;
   logic [nts_pkg::FIELD_W-1:0]  rem_ff, rem_in;
   logic [nts_pkg::FIELD_W-1:0]  den_ff, den_in;
   logic [nts_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic                          valid_ff, valid_in;
   logic [1:0]                    kind_ff, kind_in;
   logic                          cont_ff, cont_in;
   logic [nts_pkg::ONSET_W-1:0]   onset_ff, onset_in;
   logic [nts_pkg::FIELD_W-1:0]   pitch_ff, pitch_in;
   logic [nts_pkg::FIELD_W-1:0]   dur_ff, dur_in;
   logic [nts_pkg::FIELD_W-1:0]   vel_ff, vel_in;
   logic [nts_pkg::FIELD_W-1:0]   trk_ff, trk_in;
   logic                          err_ff, err_in;

   logic                          out_free;
   logic [nts_pkg::FIELD_W:0]     rem_shift;
   logic [nts_pkg::FIELD_W:0]     rem_diff;
   logic                          q_bit;
   logic [nts_pkg::PROD_W-1:0]    quot_next;

   assign out_free  = !valid_ff || rsp_ready;

   // restoring division, one quotient bit per cycle
   assign rem_shift = {rem_ff, quot_ff[nts_pkg::PROD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign q_bit     = (rem_shift >= {1'b0, den_ff});
   assign quot_next = {quot_ff[nts_pkg::PROD_W-2:0], q_bit};

   always_comb begin
      state_in = state_ff;
      tpwn_in  = tpwn_ff;
      start_in = start_ff;
      len_in   = len_ff;
      time_in  = time_ff;
      flag_in  = flag_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      cont_in  = cont_ff;
      onset_in = onset_ff;
      pitch_in = pitch_ff;
      dur_in   = dur_ff;
      vel_in   = vel_ff;
      trk_in   = trk_ff;
      err_in   = err_ff;
      q_pop    = 1'b0;

      if (valid_ff && rsp_ready) valid_in = 1'b0;
      if (csr_write_enable) tpwn_in = csr_write_data;

      case (state_ff)
         nts_pkg::BK_RUN: begin
            if (!q_empty) begin
               case (q_op.kind)
                  nts_pkg::OP_TRACK, nts_pkg::OP_PIECE, nts_pkg::OP_NOTE: begin
                     if (out_free) begin
                        q_pop    = 1'b1;
                        valid_in = 1'b1;
                        cont_in  = 1'b0;
                        onset_in = '0;
                        pitch_in = '0;
                        dur_in   = '0;
                        vel_in   = '0;
                        trk_in   = '0;
                        err_in   = flag_ff;
                        if (q_op.kind == nts_pkg::OP_TRACK) begin
                           kind_in = nts_pkg::EV_TRACK;
                        end else if (q_op.kind == nts_pkg::OP_PIECE) begin
                           kind_in  = nts_pkg::EV_PIECE;
                           start_in = '0;
                           len_in   = '0;
                           time_in  = '0;
                           flag_in  = 1'b0;
                        end else begin
                           kind_in  = nts_pkg::EV_NOTE;
                           cont_in  = q_op.cont;
                           onset_in = nts_pkg::ONSET_W'(time_ff[nts_pkg::ONSET_BITS-1:0]);
                           pitch_in = q_op.a;
                           dur_in   = q_op.b;
                           vel_in   = q_op.vel;
                           trk_in   = q_op.track;
                        end
                     end
                  end
                  nts_pkg::OP_POS: begin
                     q_pop   = 1'b1;
                     time_in = start_ff + nts_pkg::TIME_W'(q_op.a);
                  end
                  nts_pkg::OP_MEASURE: begin
                     q_pop    = 1'b1;
                     start_in = start_ff + len_ff;
                     if (q_op.b == '0) begin
                        len_in  = '0;
                        flag_in = 1'b1;
                     end else begin
                        quot_in  = nts_pkg::PROD_W'(q_op.a) * nts_pkg::PROD_W'(tpwn_ff);
                        rem_in   = '0;
                        den_in   = q_op.b;
                        cnt_in   = '0;
                        state_in = nts_pkg::BK_DIV;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         nts_pkg::BK_DIV: begin
            quot_in = quot_next;
            rem_in  = q_bit ? rem_diff[nts_pkg::FIELD_W-1:0]
                            : rem_shift[nts_pkg::FIELD_W-1:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == nts_pkg::DIV_CNT_W'(nts_pkg::DIV_STEPS - 1)) begin
               len_in   = nts_pkg::TIME_W'(quot_next);
               flag_in  = 1'b0;
               state_in = nts_pkg::BK_RUN;
            end
         end
         default: begin
            state_in = nts_pkg::BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nts_pkg::BK_RUN;
         tpwn_ff  <= nts_pkg::TPWN_RESET;
         start_ff <= '0;
         len_ff   <= '0;
         time_ff  <= '0;
         flag_ff  <= 1'b0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tpwn_ff  <= tpwn_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         time_ff  <= time_in;
         flag_ff  <= flag_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      kind_ff  <= kind_in;
      cont_ff  <= cont_in;
      onset_ff <= onset_in;
      pitch_ff <= pitch_in;
      dur_ff   <= dur_in;
      vel_ff   <= vel_in;
      trk_ff   <= trk_in;
      err_ff   <= err_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_continued      = cont_ff;
   assign rsp_onset_tick     = onset_ff;
   assign rsp_pitch_value    = pitch_ff;
   assign rsp_duration_value = dur_ff;
   assign rsp_velocity_value = vel_ff;
   assign rsp_track_number   = trk_ff;
   assign rsp_divide_error   = err_ff;

endmodule

// ----- rtl/note_token_stream_parser.sv -----
// Top level of the note token stream parser: front end, op queue, back end.
// Depends on nts_pkg, nts_front, nts_queue and nts_back.
//
//   channel  dir  handshake                     payload
//   req      in   req_valid / req_ready         req_stream_byte
//   rsp      out  rsp_valid / rsp_ready         event kind, note fields, divide error
//   csr      in   csr_write_enable              csr_write_data (ticks per whole note)
//
// The front end takes one byte per cycle while the 4-entry op queue has room.
// Position ops never wait for the output register; a measure op with a nonzero
// denominator runs through the bit-serial divider, which holds off all other ops until done.
// Results sit in one output register; track, piece and note ops stall while it is held.
// Synchronous reset, no clearing pass: the block takes bytes in the cycle after reset.

module note_token_stream_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_stream_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_event_kind,
   output logic                           rsp_continued,
   output logic [nts_pkg::ONSET_W-1:0]    rsp_onset_tick,
   output logic [nts_pkg::FIELD_W-1:0]    rsp_pitch_value,
   output logic [nts_pkg::FIELD_W-1:0]    rsp_duration_value,
   output logic [nts_pkg::FIELD_W-1:0]    rsp_velocity_value,
   output logic [nts_pkg::FIELD_W-1:0]    rsp_track_number,
   output logic                           rsp_divide_error,
   input  logic                           csr_write_enable,
   input  logic [nts_pkg::TPWN_W-1:0]     csr_write_data
);

   logic            q_push;
   nts_pkg::op_type q_push_op;
   logic            q_pop;
   nts_pkg::op_type q_pop_op;
   logic            q_full;
   logic            q_empty;

   nts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_valid),
      .byte_data  (req_stream_byte),
      .queue_full (q_full),
      .byte_ready (req_ready),
      .push       (q_push),
      .push_op    (q_push_op)
   );

   nts_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .pop     (q_pop),
      .pop_op  (q_pop_op),
      .full    (q_full),
      .empty   (q_empty)
   );

   nts_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .q_empty            (q_empty),
      .q_op               (q_pop_op),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_continued      (rsp_continued),
      .rsp_onset_tick     (rsp_onset_tick),
      .rsp_pitch_value    (rsp_pitch_value),
      .rsp_duration_value (rsp_duration_value),
      .rsp_velocity_value (rsp_velocity_value),
      .rsp_track_number   (rsp_track_number),
      .rsp_divide_error   (rsp_divide_error)
   );

endmodule

// ----- test/note_token_stream_parser_tb.sv -----
// Self-checking testbench for note_token_stream_parser: byte stimulus, event scoreboard.
// Depends on nts_pkg and the note_token_stream_parser RTL.
`timescale 1ns / 1ps

module note_token_stream_parser_tb;

   typedef struct {
      logic [1:0]                  kind;
      logic                        continued;
      logic [nts_pkg::ONSET_W-1:0] onset;
      logic [7:0]                  pitch;
      logic [7:0]                  duration;
      logic [7:0]                  velocity;
      logic [7:0]                  track;
      logic                        divide_error;
   } note_event_type;

   class event_scoreboard;
      logic [nts_pkg::TPWN_W-1:0] tpwn;
      nts_pkg::parse_mode_type    mode;
      logic [7:0]                 acc;
      logic                       neg;
      logic                       at_start;
      logic [7:0]                 numer;
      logic                       p_cont;
      logic [7:0]                 p_pitch;
      logic [7:0]                 p_dur;
      logic [7:0]                 p_vel;
      logic [31:0]                meas_start;
      logic [31:0]                meas_len;
      logic [31:0]                cur_time;
      logic                       div_err;
      note_event_type             expected_events[$];
      int                         mismatches;

      function new();
         tpwn       = nts_pkg::TPWN_RESET;
         mode       = nts_pkg::PM_IDLE;
         acc        = '0;
         neg        = 1'b0;
         at_start   = 1'b1;
         numer      = '0;
         p_cont     = 1'b0;
         p_pitch    = '0;
         p_dur      = '0;
         p_vel      = '0;
         meas_start = '0;
         meas_len   = '0;
         cur_time   = '0;
         div_err    = 1'b0;
         mismatches = 0;
      endfunction

      function void queue_event(note_event_type e);
         expected_events = {expected_events, e};
      endfunction

      function int digit(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c) - int'("0");
         if (c >= "A" && c <= "Z") return int'(c) - int'("A") + 10;
         return -1;
      endfunction

      function void feed(logic [7:0] c);
         int d;
         if (at_start && c == nts_pkg::CH_MINUS) begin
            neg      = 1'b1;
            at_start = 1'b0;
            return;
         end
         at_start = 1'b0;
         d = digit(c);
         if (d >= 0) acc = 8'(int'(acc) * 36 + d);
      endfunction

      function logic [7:0] take();
         logic [7:0] v;
         v        = neg ? 8'(0 - acc) : acc;
         acc      = '0;
         neg      = 1'b0;
         at_start = 1'b1;
         return v;
      endfunction

      // Advances the parser by one accepted byte; queues the event it causes, if any.
      function void parse_byte(logic [7:0] c);
         note_event_type e;
         logic [7:0]     v;
         e = '{kind: nts_pkg::EV_NOTE, continued: 1'b0, onset: '0, pitch: '0,
               duration: '0, velocity: '0, track: '0, divide_error: div_err};
         case (mode)
            nts_pkg::PM_IDLE: begin
               if (c == nts_pkg::CH_R) begin
                  mode   = nts_pkg::PM_SKIPR;
                  e.kind = nts_pkg::EV_TRACK;
                  queue_event(e);
               end else if (c == nts_pkg::CH_M) begin
                  meas_start = meas_start + meas_len;
                  mode       = nts_pkg::PM_NUMER;
               end else if (c == nts_pkg::CH_P) begin
                  mode = nts_pkg::PM_POS;
               end else if (c == nts_pkg::CH_N) begin
                  p_cont = 1'b0;
                  mode   = nts_pkg::PM_NMARK;
               end else if (c == nts_pkg::CH_NL) begin
                  e.kind = nts_pkg::EV_PIECE;
                  queue_event(e);
                  meas_start = '0;
                  meas_len   = '0;
                  cur_time   = '0;
                  div_err    = 1'b0;
               end
            end
            nts_pkg::PM_SKIPR: if (c == nts_pkg::CH_SPACE) mode = nts_pkg::PM_IDLE;
            nts_pkg::PM_NUMER: begin
               if (c == nts_pkg::CH_SLASH) begin
                  numer = take();
                  mode  = nts_pkg::PM_DENOM;
               end else feed(c);
            end
            nts_pkg::PM_DENOM: begin
               if (c == nts_pkg::CH_SPACE) begin
                  v = take();
                  if (v == 0) begin
                     meas_len = '0;
                     div_err  = 1'b1;
                  end else begin
                     meas_len = (32'(numer) * 32'(tpwn)) / 32'(v);
                     div_err  = 1'b0;
                  end
                  mode = nts_pkg::PM_IDLE;
               end else feed(c);
            end
            nts_pkg::PM_POS: begin
               if (c == nts_pkg::CH_SPACE) begin
                  cur_time = meas_start + 32'(take());
                  mode     = nts_pkg::PM_IDLE;
               end else feed(c);
            end
            nts_pkg::PM_NMARK: begin
               if (c == nts_pkg::CH_TILDE) begin
                  p_cont = 1'b1;
                  mode   = nts_pkg::PM_NSKIP;
               end else mode = nts_pkg::PM_PITCH;
            end
            nts_pkg::PM_NSKIP: mode = nts_pkg::PM_PITCH;
            nts_pkg::PM_PITCH, nts_pkg::PM_DUR, nts_pkg::PM_VEL: begin
               if (c == nts_pkg::CH_COLON) begin
                  v = take();
                  if (mode == nts_pkg::PM_PITCH) begin
                     p_pitch = v;
                     mode    = nts_pkg::PM_DUR;
                  end else if (mode == nts_pkg::PM_DUR) begin
                     p_dur = v;
                     mode  = nts_pkg::PM_VEL;
                  end else begin
                     p_vel = v;
                     mode  = nts_pkg::PM_TRACK;
                  end
               end else feed(c);
            end
            nts_pkg::PM_TRACK: begin
               if (c == nts_pkg::CH_SPACE) begin
                  v           = take();
                  mode        = nts_pkg::PM_IDLE;
                  e.kind      = nts_pkg::EV_NOTE;
                  e.continued = p_cont;
                  e.onset     = cur_time[nts_pkg::ONSET_W-1:0];
                  e.pitch     = p_pitch;
                  e.duration  = p_dur;
                  e.velocity  = p_vel;
                  e.track     = v;
                  queue_event(e);
               end else feed(c);
            end
            default: mode = nts_pkg::PM_IDLE;
         endcase
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(note_event_type got);
         note_event_type want;
         if (expected_events.size() == 0) begin
            $error("event_kind: expected none, actual %0d", got.kind);
            mismatches++;
            return;
         end
         want = expected_events.pop_front();
         compare_field("event_kind", want.kind, got.kind);
         compare_field("continued", want.continued, got.continued);
         compare_field("onset_tick", want.onset, got.onset);
         compare_field("pitch_value", want.pitch, got.pitch);
         compare_field("duration_value", want.duration, got.duration);
         compare_field("velocity_value", want.velocity, got.velocity);
         compare_field("track_number", want.track, got.track);
         compare_field("divide_error", want.divide_error, got.divide_error);
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_stream_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [1:0]                   rsp_event_kind;
   logic                         rsp_continued;
   logic [nts_pkg::ONSET_W-1:0]  rsp_onset_tick;
   logic [nts_pkg::FIELD_W-1:0]  rsp_pitch_value;
   logic [nts_pkg::FIELD_W-1:0]  rsp_duration_value;
   logic [nts_pkg::FIELD_W-1:0]  rsp_velocity_value;
   logic [nts_pkg::FIELD_W-1:0]  rsp_track_number;
   logic                         rsp_divide_error;
   logic                         csr_write_enable = 1'b0;
   logic [nts_pkg::TPWN_W-1:0]   csr_write_data = '0;

   logic                         idle_on = 1'b1;
   int                           hold_requests = 0;
   int                           phase_bytes;

   event_scoreboard sb = new();

   note_token_stream_parser u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_stream_byte    (req_stream_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_continued      (rsp_continued),
      .rsp_onset_tick     (rsp_onset_tick),
      .rsp_pitch_value    (rsp_pitch_value),
      .rsp_duration_value (rsp_duration_value),
      .rsp_velocity_value (rsp_velocity_value),
      .rsp_track_number   (rsp_track_number),
      .rsp_divide_error   (rsp_divide_error),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("note_token_stream_parser: mismatch");
      $finish;
   end

   // Result side: check every transfer, then pick ready for the next edge.
   initial begin
      int             hold;
      int             served;
      note_event_type got;
      hold   = 0;
      served = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.kind         = rsp_event_kind;
            got.continued    = rsp_continued;
            got.onset        = rsp_onset_tick;
            got.pitch        = rsp_pitch_value;
            got.duration     = rsp_duration_value;
            got.velocity     = rsp_velocity_value;
            got.track        = rsp_track_number;
            got.divide_error = rsp_divide_error;
            sb.check_result(got);
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_requests != served) begin
            // long hold-off: queue fills and the input side backs up
            served = hold_requests;
            hold   = 400;
            rsp_ready <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(logic [7:0] b);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.parse_byte(b);
      phase_bytes++;
   endtask

   task automatic send_field(logic [7:0] term);
      int         r;
      int         len;
      int         k;
      logic [7:0] ch;
      if ($urandom_range(0, 3) == 0) send_byte(nts_pkg::CH_MINUS);
      r   = $urandom_range(0, 19);
      len = (r == 0) ? 0 : (r < 17) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      repeat (len) begin
         k = $urandom_range(0, 15);
         if (k == 0) begin
            ch = 8'($urandom_range(0, 255));
            if (ch == term) ch = nts_pkg::CH_MINUS;
         end else if (k < 8) begin
            ch = 8'("0" + $urandom_range(0, 9));
         end else begin
            ch = 8'("A" + $urandom_range(0, 25));
         end
         send_byte(ch);
      end
   endtask

   task automatic send_token();
      int         sel;
      logic [7:0] ch;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         send_byte(nts_pkg::CH_R);
         repeat ($urandom_range(0, 3)) begin
            ch = 8'($urandom_range(0, 255));
            if (ch == nts_pkg::CH_SPACE) ch = nts_pkg::CH_R;
            send_byte(ch);
         end
         send_byte(nts_pkg::CH_SPACE);
      end else if (sel < 20) begin
         send_byte(nts_pkg::CH_M);
         send_field(nts_pkg::CH_SLASH);
         send_byte(nts_pkg::CH_SLASH);
         send_field(nts_pkg::CH_SPACE);
         send_byte(nts_pkg::CH_SPACE);
      end else if (sel < 35) begin
         send_byte(nts_pkg::CH_P);
         send_field(nts_pkg::CH_SPACE);
         send_byte(nts_pkg::CH_SPACE);
      end else if (sel < 85) begin
         send_byte(nts_pkg::CH_N);
         if ($urandom_range(0, 2) == 0) send_byte(nts_pkg::CH_TILDE);
         send_byte(8'($urandom_range(0, 255)));
         repeat (3) begin
            send_field(nts_pkg::CH_COLON);
            send_byte(nts_pkg::CH_COLON);
         end
         send_field(nts_pkg::CH_SPACE);
         send_byte(nts_pkg::CH_SPACE);
      end else if (sel < 91) begin
         send_byte(nts_pkg::CH_NL);
      end else begin
         // noise and broken tokens
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Drain outstanding events, then allow for measure ops still in the divider.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_events.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_tpwn(logic [nts_pkg::TPWN_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      sb.tpwn = v;
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      string                      directed;
      logic [nts_pkg::TPWN_W-1:0] tpwn_plan[4];
      int                         waited;
      tpwn_plan[0] = 12'd4095;
      tpwn_plan[1] = 12'd1;
      tpwn_plan[2] = 12'($urandom_range(2, 4094));
      tpwn_plan[3] = nts_pkg::TPWN_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // track, zero denominator, negative position, continued note, piece end
      directed = "R M4/0 P-1 N~xZ:-1:Z:ZZ \n";
      for (int i = 0; i < directed.len(); i++) send_byte(directed[i]);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte("Q");

      for (int ph = 0; ph < 4; ph++) begin
         settle();
         write_tpwn(tpwn_plan[ph]);
         if (ph == 1) hold_requests <= hold_requests + 1;
         if (ph == 3) idle_on <= 1'b0;
         phase_bytes = 0;
         while (phase_bytes < 250) send_token();
      end

      req_valid <= 1'b0;
      waited = 0;
      while (sb.expected_events.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (150) @(posedge clock);
      if (sb.expected_events.size() != 0) begin
         $error("event_kind: %0d expected events never arrived", sb.expected_events.size());
         sb.mismatches++;
      end
      if (sb.mismatches == 0) begin
         $display("note_token_stream_parser: match");
      end else begin
         $display("note_token_stream_parser: mismatch");
      end
      $finish;
   end

endmodule
